// ----- rtl/core/aabbbp_pkg.sv -----
// Shared types and constants for the box broad-phase pair finder.
package aabbbp_pkg;

  localparam int unsigned MAX_BOXES_DEF = 8;
  localparam int unsigned ID_W          = 16;
  localparam int unsigned CRD_W         = 32;
  localparam int unsigned KEY_W         = 2 * ID_W;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [CRD_W-1:0] min_x;
    logic signed [CRD_W-1:0] max_x;
    logic signed [CRD_W-1:0] min_y;
    logic signed [CRD_W-1:0] max_y;
    logic signed [CRD_W-1:0] min_z;
    logic signed [CRD_W-1:0] max_z;
  } box_t;

  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] key;
  } best_t;

endpackage

// ----- rtl/core/aabbbp_cell.sv -----
// One storage cell: holds a box, tests it against the broadcast box, keeps the best pair key.
module aabbbp_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          ld_i,
  input  logic                          act_i,
  input  aabbbp_pkg::box_t              box_i,
  output aabbbp_pkg::box_t              box_o,
  input  logic                          bc_en_i,
  input  aabbbp_pkg::box_t              bc_i,
  input  logic                          prev_vld_i,
  input  logic [aabbbp_pkg::KEY_W-1:0]  prev_i,
  input  logic                          clr_i,
  input  logic                          prop_i,
  input  aabbbp_pkg::best_t             left_i,
  output aabbbp_pkg::best_t             best_o
);

  aabbbp_pkg::box_t  box_q;
  aabbbp_pkg::best_t best_q, best_d;
  logic                         hit;
  logic                         cand_ok;
  logic [aabbbp_pkg::KEY_W-1:0] key;

  always_comb begin
    hit = (box_q.min_x <= bc_i.max_x) && (bc_i.min_x <= box_q.max_x) &&
          (box_q.min_y <= bc_i.max_y) && (bc_i.min_y <= box_q.max_y) &&
          (box_q.min_z <= bc_i.max_z) && (bc_i.min_z <= box_q.max_z);
    key = (box_q.id < bc_i.id) ? {box_q.id, bc_i.id} : {bc_i.id, box_q.id};
    cand_ok = hit && (box_q.id != bc_i.id) && (!prev_vld_i || (key > prev_i)) &&
              (!best_q.found || (key < best_q.key));
    best_d = best_q;
    priority if (clr_i) begin
      best_d.found = 1'b0;
    end else if (bc_en_i && act_i && cand_ok) begin
      best_d.found = 1'b1;
      best_d.key   = key;
    end else if (prop_i && left_i.found &&
                 (!best_q.found || (left_i.key < best_q.key))) begin
      best_d = left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      box_q <= box_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else begin
      best_q <= best_d;
    end
  end

  assign box_o  = box_q;
  assign best_o = best_q;

endmodule

// ----- rtl/core/aabb_broadphase_overlap_pairs.sv -----
// Top level: frame loader, scan sequencer and result register over a chain of box cells.
//
//  channel | direction | handshake                    | payload
//  box     | in        | box_valid_i / box_stall_o    | box_id, bounds, last_box
//  pair    | out       | out_valid_o / out_stall_i    | pair_valid, ids, last_pair, overflow
//
// Box beats load while box_stall_o is low. After the last box each pass runs a broadcast
// scan over the stored boxes, a chain reduction along the cells and a decide step. A pair
// is offered one pass after it is found, so in a frame with pairs the first beat follows two
// passes and the frame ends with a pass that finds nothing; each beat holds until taken.
// box_stall_o is high from the last box until the final result beat is taken.
// Reset empties the frame.
module aabb_broadphase_overlap_pairs #(
  parameter int unsigned MAX_BOXES = aabbbp_pkg::MAX_BOXES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                box_valid_i,
  output logic                                box_stall_o,
  input  logic [aabbbp_pkg::ID_W-1:0]         box_id_i,
  input  logic signed [aabbbp_pkg::CRD_W-1:0] min_x_i,
  input  logic signed [aabbbp_pkg::CRD_W-1:0] max_x_i,
  input  logic signed [aabbbp_pkg::CRD_W-1:0] min_y_i,
  input  logic signed [aabbbp_pkg::CRD_W-1:0] max_y_i,
  input  logic signed [aabbbp_pkg::CRD_W-1:0] min_z_i,
  input  logic signed [aabbbp_pkg::CRD_W-1:0] max_z_i,
  input  logic                                last_box_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                pair_valid_o,
  output logic [aabbbp_pkg::ID_W-1:0]         id_low_o,
  output logic [aabbbp_pkg::ID_W-1:0]         id_high_o,
  output logic                                last_pair_o,
  output logic                                overflow_o
);

  localparam int unsigned CW = $clog2(MAX_BOXES + 1);
  localparam int unsigned IW = $clog2(MAX_BOXES);
  localparam int unsigned KW = aabbbp_pkg::KEY_W;
  localparam int unsigned IDW = aabbbp_pkg::ID_W;

  typedef enum logic [2:0] {S_LOAD, S_SCAN, S_PROP, S_DECIDE, S_OUT} state_e;

  state_e            state_q;
  logic [CW-1:0]     count_q;
  logic [CW-1:0]     step_q;
  logic              drop_q;
  logic              pend_vld_q;
  logic [KW-1:0]     pend_q;
  logic              done_q;
  logic              valid_q, pv_q, last_q, ovf_q;
  logic [KW-1:0]     okey_q;

  aabbbp_pkg::box_t  in_box, bc_box;
  aabbbp_pkg::box_t  box_all  [MAX_BOXES];
  aabbbp_pkg::best_t best_all [MAX_BOXES];
  aabbbp_pkg::best_t res;
  logic              accept, clr;

  assign accept = box_valid_i && !box_stall_o;
  assign box_stall_o = (state_q != S_LOAD);
  assign res = best_all[MAX_BOXES-1];
  assign bc_box = box_all[step_q[IW-1:0]];
  assign clr = (accept && last_box_i) || (state_q == S_DECIDE);

  always_comb begin
    in_box.id    = box_id_i;
    in_box.min_x = min_x_i;
    in_box.max_x = max_x_i;
    in_box.min_y = min_y_i;
    in_box.max_y = max_y_i;
    in_box.min_z = min_z_i;
    in_box.max_z = max_z_i;
  end

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    aabbbp_pkg::best_t left;
    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_link
      assign left = best_all[i-1];
    end
    aabbbp_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ld_i       (accept && (count_q == CW'(i))),
      .act_i      (count_q > CW'(i)),
      .box_i      (in_box),
      .box_o      (box_all[i]),
      .bc_en_i    (state_q == S_SCAN),
      .bc_i       (bc_box),
      .prev_vld_i (pend_vld_q),
      .prev_i     (pend_q),
      .clr_i      (clr),
      .prop_i     (state_q == S_PROP),
      .left_i     (left),
      .best_o     (best_all[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      count_q    <= '0;
      step_q     <= '0;
      drop_q     <= 1'b0;
      pend_vld_q <= 1'b0;
      pend_q     <= '0;
      done_q     <= 1'b0;
      valid_q    <= 1'b0;
      pv_q       <= 1'b0;
      last_q     <= 1'b0;
      ovf_q      <= 1'b0;
      okey_q     <= '0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (accept) begin
            if (count_q < CW'(MAX_BOXES)) begin
              count_q <= count_q + 1'b1;
            end else begin
              drop_q <= 1'b1;
            end
            if (last_box_i) begin
              step_q  <= '0;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (step_q == count_q - 1'b1) begin
            step_q  <= '0;
            state_q <= S_PROP;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_PROP: begin
          if (step_q == CW'(MAX_BOXES - 2)) begin
            step_q  <= '0;
            state_q <= S_DECIDE;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_DECIDE: begin
          ovf_q <= drop_q;
          if (res.found) begin
            pend_q     <= res.key;
            pend_vld_q <= 1'b1;
            done_q     <= 1'b0;
            if (pend_vld_q) begin
              valid_q <= 1'b1;
              pv_q    <= 1'b1;
              last_q  <= 1'b0;
              okey_q  <= pend_q;
              state_q <= S_OUT;
            end else begin
              state_q <= S_SCAN;
            end
          end else begin
            valid_q    <= 1'b1;
            pv_q       <= pend_vld_q;
            last_q     <= 1'b1;
            okey_q     <= pend_vld_q ? pend_q : '0;
            done_q     <= 1'b1;
            pend_vld_q <= 1'b0;
            count_q    <= '0;
            drop_q     <= 1'b0;
            state_q    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            valid_q <= 1'b0;
            step_q  <= '0;
            state_q <= done_q ? S_LOAD : S_SCAN;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign out_valid_o  = valid_q;
  assign pair_valid_o = pv_q;
  assign id_low_o     = okey_q[KW-1:IDW];
  assign id_high_o    = okey_q[IDW-1:0];
  assign last_pair_o  = last_q;
  assign overflow_o   = ovf_q;

  a_out_in_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == S_OUT)) else $error("result offered outside output state");
  a_no_load_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> box_stall_o) else $error("box port open while result pending");
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pair_valid_o) |-> last_pair_o) else $error("empty result not last");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_BOXES)) else $error("box count beyond capacity");
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE && res.found && pend_vld_q) |-> (res.key > pend_q))
    else $error("pair keys not ascending");

endmodule

// ----- bench/tb_aabb_broadphase_overlap_pairs.sv -----
// Testbench for the box broad-phase pair finder: random frames, predicted pair lists, checks.
`timescale 1ns / 100ps
module tb_aabb_broadphase_overlap_pairs;

  localparam int unsigned NBOX  = aabbbp_pkg::MAX_BOXES_DEF;
  localparam int unsigned ID_W  = aabbbp_pkg::ID_W;
  localparam int unsigned CRD_W = aabbbp_pkg::CRD_W;
  localparam int unsigned KEY_W = aabbbp_pkg::KEY_W;

  typedef struct packed {
    aabbbp_pkg::box_t box;
    logic last;
  } beat_t;

  typedef struct packed {
    logic            pv;
    logic [ID_W-1:0] lo;
    logic [ID_W-1:0] hi;
    logic            lp;
    logic            ov;
  } pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic box_valid_i = 1'b0;
  logic box_stall_o;
  logic [ID_W-1:0] box_id_i = '0;
  logic signed [CRD_W-1:0] min_x_i = '0, max_x_i = '0, min_y_i = '0;
  logic signed [CRD_W-1:0] max_y_i = '0, min_z_i = '0, max_z_i = '0;
  logic last_box_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic pair_valid_o, last_pair_o, overflow_o;
  logic [ID_W-1:0] id_low_o, id_high_o;

  aabb_broadphase_overlap_pairs DUT (.*);

  always #10 clk_i = ~clk_i;

  beat_t pending_boxes[$];
  pair_t expected_pairs[$];
  aabbbp_pkg::box_t frame_store[NBOX];
  int    frame_count = 0;
  logic  frame_dropped = 1'b0;
  int    errors = 0;
  int    idle_pct = 38;
  int    hold_cycles = 0;
  logic  send_pause = 1'b0;

  function automatic logic axis_meets(logic signed [CRD_W-1:0] amin, amax, bmin, bmax);
    return (amin <= bmax) && (bmin <= amax);
  endfunction

  function automatic logic boxes_meet(aabbbp_pkg::box_t a, aabbbp_pkg::box_t b);
    return axis_meets(a.min_x, a.max_x, b.min_x, b.max_x)
        && axis_meets(a.min_y, a.max_y, b.min_y, b.max_y)
        && axis_meets(a.min_z, a.max_z, b.min_z, b.max_z);
  endfunction

  task automatic predict_pairs(beat_t bt);
    logic [KEY_W-1:0] keys[$];
    logic [KEY_W-1:0] k;
    logic dup;
    pair_t p;
    if (frame_count < NBOX) begin
      frame_store[frame_count] = bt.box;
      frame_count++;
    end else begin
      frame_dropped = 1'b1;
    end
    if (!bt.last) return;
    for (int a = 0; a < frame_count; a++)
      for (int b = a + 1; b < frame_count; b++) begin
        if (frame_store[a].id == frame_store[b].id) continue;
        if (!boxes_meet(frame_store[a], frame_store[b])) continue;
        k = (frame_store[a].id < frame_store[b].id) ? {frame_store[a].id, frame_store[b].id}
                                                    : {frame_store[b].id, frame_store[a].id};
        dup = 1'b0;
        foreach (keys[i]) if (keys[i] == k) dup = 1'b1;
        if (!dup) keys = {keys, k};
      end
    keys.sort();
    if (keys.size() == 0) begin
      p = '{1'b0, '0, '0, 1'b1, frame_dropped};
      expected_pairs = {expected_pairs, p};
    end
    foreach (keys[i]) begin
      p = '{1'b1, keys[i][KEY_W-1:ID_W], keys[i][ID_W-1:0], i == keys.size() - 1,
            frame_dropped};
      expected_pairs = {expected_pairs, p};
    end
    frame_count = 0;
    frame_dropped = 1'b0;
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (box_valid_i && !box_stall_o) begin
        predict_pairs(pending_boxes.pop_front());
      end
      if ((!box_valid_i || !box_stall_o)) begin
        if (pending_boxes.size() > 0 && !send_pause && $urandom_range(99) >= idle_pct) begin
          box_valid_i <= 1'b1;
          box_id_i    <= pending_boxes[0].box.id;
          min_x_i     <= pending_boxes[0].box.min_x;
          max_x_i     <= pending_boxes[0].box.max_x;
          min_y_i     <= pending_boxes[0].box.min_y;
          max_y_i     <= pending_boxes[0].box.max_y;
          min_z_i     <= pending_boxes[0].box.min_z;
          max_z_i     <= pending_boxes[0].box.max_z;
          last_box_i  <= pending_boxes[0].last;
        end else begin
          box_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pair_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{pair_valid_o, id_low_o, id_high_o, last_pair_o, overflow_o};
        if (expected_pairs.size() == 0) begin
          report_mismatch("unexpected pair beat");
        end else begin
          want = expected_pairs.pop_front();
          if (got.pv !== want.pv) report_mismatch("pair_valid");
          if (got.lo !== want.lo) report_mismatch("id_low");
          if (got.hi !== want.hi) report_mismatch("id_high");
          if (got.lp !== want.lp) report_mismatch("last_pair");
          if (got.ov !== want.ov) report_mismatch("overflow");
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < idle_pct);
      end
    end
  end

  function automatic logic signed [CRD_W-1:0] rand_crd(int mode);
    case (mode)
      0: return $signed($urandom);
      1: return $signed(32'($urandom_range(0, 600)) - 32'sd300);
      default: return $signed(32'($urandom_range(0, 8)) - 32'sd4);
    endcase
  endfunction

  function automatic beat_t make_box(logic [ID_W-1:0] id, logic last, int mode);
    beat_t bt;
    logic signed [CRD_W-1:0] a, b;
    bt.box.id = id;
    bt.last = last;
    for (int ax = 0; ax < 3; ax++) begin
      a = rand_crd(mode);
      b = rand_crd(mode);
      if (mode != 0 && $urandom_range(9) != 0 && a > b) begin
        a = a ^ b; b = a ^ b; a = a ^ b;
      end
      case (ax)
        0: begin bt.box.min_x = a; bt.box.max_x = b; end
        1: begin bt.box.min_y = a; bt.box.max_y = b; end
        default: begin bt.box.min_z = a; bt.box.max_z = b; end
      endcase
    end
    return bt;
  endfunction

  task automatic queue_frame(int n, int mode);
    logic [ID_W-1:0] id;
    for (int i = 0; i < n; i++) begin
      id = ($urandom_range(9) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      pending_boxes = {pending_boxes, make_box(id, i == n - 1, mode)};
    end
  endtask

  task automatic wait_drain();
    while (pending_boxes.size() > 0 || box_valid_i || expected_pairs.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    beat_t bt;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // extremes: full-range box, touching box, single box, all-ones ids
    bt.box = '{16'h0000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
               32'sh80000000, 32'sh7fffffff};
    bt.last = 1'b0;
    pending_boxes = {pending_boxes, bt};
    bt.box = '{16'hffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
               32'sh7fffffff, 32'sh7fffffff};
    pending_boxes = {pending_boxes, bt};
    bt.box = '{16'h5555, 32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh0, 32'sh0, 32'sh0};
    pending_boxes = {pending_boxes, bt};
    bt.box = '{16'hffff, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0};
    bt.last = 1'b1;
    pending_boxes = {pending_boxes, bt};
    queue_frame(1, 1);
    queue_frame(10, 2);
    queue_frame(8, 2);
    wait_drain();
    // long receiver hold-off while boxes keep coming
    hold_cycles = 400;
    queue_frame(NBOX, 2);
    queue_frame(NBOX, 2);
    while (pending_boxes.size() > NBOX) @(posedge clk_i);
    send_pause = 1'b1;
    while (expected_pairs.size() > 0 || box_valid_i) @(posedge clk_i);
    send_pause = 1'b0;
    wait_drain();
    idle_pct = 0;
    queue_frame(6, 2);
    queue_frame(9, 1);
    wait_drain();
    idle_pct = 38;
    while (pending_boxes.size() < 96) queue_frame($urandom_range(1, 11), $urandom_range(0, 2));
    wait_drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end
endmodule

// ----- aabb_broadphase_overlap_pairs.f -----
rtl/core/aabbbp_pkg.sv
rtl/core/aabbbp_cell.sv
rtl/core/aabb_broadphase_overlap_pairs.sv
bench/tb_aabb_broadphase_overlap_pairs.sv
